// ===== hw/rtl/rdconv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading conversion package
// Types, constants and the CRC-8 helper shared by the reading conversion
// pipeline.
// ----------------------------------------------------------------------------
package rdconv_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_CHANNEL = 2'd1,
    STATUS_XFER_FAIL   = 2'd2,
    STATUS_CRC_ERR     = 2'd3
  } status_e;

  // Request codes that select a channel; the other codes are invalid.
  typedef enum logic [1:0] {
    ACT_TEMP  = 2'd0,
    ACT_HUMID = 2'd1
  } action_e;

  // Sensor variant register values that pick a specific sub-address.
  localparam logic [7:0] VariantA = 8'd1;
  localparam logic [7:0] VariantB = 8'd2;

  localparam logic [7:0] AddrVariantA = 8'hf6;
  localparam logic [7:0] AddrVariantB = 8'he0;
  localparam logic [7:0] AddrDefault  = 8'hfd;

  // CRC-8 with polynomial 0x31, start value 0xff, MSB first.
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hff;

  // Scaling to milli-units: (raw * mul) >> 13, minus an offset.
  localparam int unsigned RawW    = 16;
  localparam int unsigned MulW    = 15;
  localparam int unsigned ProdW   = RawW + MulW;
  localparam int unsigned ScaleShift = 13;
  localparam int unsigned ScaledW = ProdW - ScaleShift;   // unsigned scaled value
  localparam int unsigned SignedW = ScaledW + 1;          // after offset
  localparam logic [MulW-1:0] TempMul  = 15'h5573;
  localparam logic [MulW-1:0] HumidMul = 15'h3d09;
  localparam logic signed [SignedW-1:0] TempOfs  = 19'sd45000;
  localparam logic signed [SignedW-1:0] HumidOfs = 19'sd6000;

  // Division by 1000 through a reciprocal: q = (mag * 134218) >> 27.
  // Exact for every magnitude below 2^17.
  localparam int unsigned MagW    = 17;
  localparam int unsigned RecipW  = 18;
  localparam int unsigned RecipShift = 27;
  localparam logic [RecipW-1:0] RecipMul = 18'd134218;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned RemW    = 10;
  localparam logic [RemW-1:0] Divisor = 10'd1000;

  localparam int unsigned WholeW = 9;
  localparam int unsigned MicroW = 21;

  // One accepted request beat.
  typedef struct packed {
    logic [1:0] action;
    logic       transfer_failed;
    logic [7:0] temp_high_byte;
    logic [7:0] temp_low_byte;
    logic [7:0] temp_check_byte;
    logic [7:0] humid_high_byte;
    logic [7:0] humid_low_byte;
    logic [7:0] humid_check_byte;
  } in_t;

  // After status decode and the scaling multiply.
  typedef struct packed {
    status_e          status;
    logic             is_temp;
    logic [ProdW-1:0] prod;
  } s1_t;

  // Sign and magnitude of the milli-unit value.
  typedef struct packed {
    status_e         status;
    logic            neg;
    logic [MagW-1:0] mag;
  } s2_t;

  // Quotient by 1000.
  typedef struct packed {
    status_e          status;
    logic             neg;
    logic [MagW-1:0]  mag;
    logic [QuotW-1:0] quot;
  } s3_t;

  // Quotient and remainder by 1000.
  typedef struct packed {
    status_e          status;
    logic             neg;
    logic [QuotW-1:0] quot;
    logic [RemW-1:0]  rem;
  } s4_t;

  // CRC-8 over one two-byte sample, high byte first.
  function automatic logic [7:0] crc8_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  c;
    logic [15:0] d;
    c = CrcInit;
    d = {hi, lo};
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ d[i]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sht_reading_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reading conversion, top level
// Converts one six-byte sensor reply into a status, a whole part, a micro
// part and the configured bus sub-address.
// ----------------------------------------------------------------------------
// The block takes one reply beat per clock while it is not stalled and
// returns one result beat per reply, in order. It is a six-register
// pipeline (input register, four working stages, output register). Each
// stage holds while the stage after it is full and stalled, so the input
// keeps taking beats until the pipeline is full. The stages hold, in order,
// the CRC check with the scale multiply, the offset and sign split, the
// reciprocal multiply for division by 1000, and the remainder. The sensor
// variant register is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while no reply is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module sht_reading_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Reply channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        transfer_failed_i,
  input  logic [7:0]  temp_high_byte_i,
  input  logic [7:0]  temp_low_byte_i,
  input  logic [7:0]  temp_check_byte_i,
  input  logic [7:0]  humid_high_byte_i,
  input  logic [7:0]  humid_low_byte_i,
  input  logic [7:0]  humid_check_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [8:0]  whole_part_o,
  output logic signed [20:0] micro_part_o,
  output logic [7:0]  device_address_o
);

  localparam int unsigned NumStages = 6;

  logic [7:0]            variant_q;
  logic [NumStages-1:0]  valid_q, valid_d, up_valid, ld;
  logic [NumStages:0]    rdy;

  rdconv_pkg::in_t       in_d, in_q;
  rdconv_pkg::s1_t       s1;
  rdconv_pkg::s2_t       s2;
  rdconv_pkg::s4_t       s4;

  logic [1:0]                         status_d, status_q;
  logic signed [rdconv_pkg::WholeW-1:0] whole_d, whole_q;
  logic signed [rdconv_pkg::MicroW-1:0] micro_d, micro_q;
  logic [7:0]                         addr_d, addr_q;
  logic [rdconv_pkg::MicroW-1:0]      micro_mag;

  // Sensor variant register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 8'd0;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  // Pipeline flow control: a stage loads when it is empty or drains.
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
    up_valid = {valid_q[NumStages-2:0], in_valid_i};
    ld       = rdy[NumStages-1:0] & up_valid;
    valid_d  = (rdy[NumStages-1:0] & up_valid) | (~rdy[NumStages-1:0] & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Input register.
  always_comb begin
    in_d.action           = action_i;
    in_d.transfer_failed  = transfer_failed_i;
    in_d.temp_high_byte   = temp_high_byte_i;
    in_d.temp_low_byte    = temp_low_byte_i;
    in_d.temp_check_byte  = temp_check_byte_i;
    in_d.humid_high_byte  = humid_high_byte_i;
    in_d.humid_low_byte   = humid_low_byte_i;
    in_d.humid_check_byte = humid_check_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      in_q <= in_d;
    end
  end

  rdconv_front u_front (
    .clk_i  (clk_i),
    .ld_i   (ld[1]),
    .item_i (in_q),
    .s1_o   (s1)
  );

  rdconv_scale u_scale (
    .clk_i (clk_i),
    .ld_i  (ld[2]),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  rdconv_div u_div (
    .clk_i (clk_i),
    .ld_i  (ld[4:3]),
    .s2_i  (s2),
    .s4_o  (s4)
  );

  // Result assembly: signed parts, zeroed unless the status is ok, and the sub-address picked by the variant register.
  always_comb begin
    micro_mag = rdconv_pkg::MicroW'(s4.rem) * rdconv_pkg::MicroW'(rdconv_pkg::Divisor);
    status_d  = s4.status;
    if (s4.status == rdconv_pkg::STATUS_OK) begin
      whole_d = s4.neg ? -$signed({1'b0, s4.quot}) : $signed({1'b0, s4.quot});
      micro_d = s4.neg ? -$signed(micro_mag) : $signed(micro_mag);
    end else begin
      whole_d = '0;
      micro_d = '0;
    end

    case (variant_q)
      rdconv_pkg::VariantA: addr_d = rdconv_pkg::AddrVariantA;
      rdconv_pkg::VariantB: addr_d = rdconv_pkg::AddrVariantB;
      default:              addr_d = rdconv_pkg::AddrDefault;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ld[NumStages-1]) begin
      status_q <= status_d;
      whole_q  <= whole_d;
      micro_q  <= micro_d;
      addr_q   <= addr_d;
    end
  end

  assign status_o         = status_q;
  assign whole_part_o     = whole_q;
  assign micro_part_o     = micro_q;
  assign device_address_o = addr_q;

endmodule

// ===== hw/rtl/rdconv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading conversion front stage
// Checks both sample CRCs, decodes the status and multiplies the selected
// raw sample by its scale factor.
// ----------------------------------------------------------------------------
module rdconv_front (
  input  logic             clk_i,
  input  logic             ld_i,
  input  rdconv_pkg::in_t  item_i,
  output rdconv_pkg::s1_t  s1_o
);

  rdconv_pkg::s1_t                     s1_d, s1_q;
  logic                                temp_ok, humid_ok, is_temp;
  logic [rdconv_pkg::RawW-1:0]         raw;
  logic [rdconv_pkg::MulW-1:0]         mul;

  // Status decode in priority order.
  always_comb begin
    temp_ok  = rdconv_pkg::crc8_pair(item_i.temp_high_byte, item_i.temp_low_byte)
               == item_i.temp_check_byte;
    humid_ok = rdconv_pkg::crc8_pair(item_i.humid_high_byte, item_i.humid_low_byte)
               == item_i.humid_check_byte;
    is_temp  = (item_i.action == rdconv_pkg::ACT_TEMP);

    if (item_i.action != rdconv_pkg::ACT_TEMP && item_i.action != rdconv_pkg::ACT_HUMID) begin
      s1_d.status = rdconv_pkg::STATUS_BAD_CHANNEL;
    end else if (item_i.transfer_failed) begin
      s1_d.status = rdconv_pkg::STATUS_XFER_FAIL;
    end else if (!temp_ok || !humid_ok) begin
      s1_d.status = rdconv_pkg::STATUS_CRC_ERR;
    end else begin
      s1_d.status = rdconv_pkg::STATUS_OK;
    end

    // Scale multiply on the selected sample.
    raw = is_temp ? {item_i.temp_high_byte, item_i.temp_low_byte}
                  : {item_i.humid_high_byte, item_i.humid_low_byte};
    mul = is_temp ? rdconv_pkg::TempMul : rdconv_pkg::HumidMul;
    s1_d.is_temp = is_temp;
    s1_d.prod    = rdconv_pkg::ProdW'(raw) * rdconv_pkg::ProdW'(mul);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// ===== hw/rtl/rdconv_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading conversion offset stage
// Drops the fraction bits, subtracts the channel offset and splits the
// milli-unit value into sign and magnitude.
// ----------------------------------------------------------------------------
module rdconv_scale (
  input  logic             clk_i,
  input  logic             ld_i,
  input  rdconv_pkg::s1_t  s1_i,
  output rdconv_pkg::s2_t  s2_o
);

  rdconv_pkg::s2_t                            s2_d, s2_q;
  logic signed [rdconv_pkg::SignedW-1:0]      scaled, ofs, mag_full;

  // Milli-unit value, then its magnitude.
  always_comb begin
    ofs      = s1_i.is_temp ? rdconv_pkg::TempOfs : rdconv_pkg::HumidOfs;
    scaled   = $signed({1'b0, s1_i.prod[rdconv_pkg::ProdW-1:rdconv_pkg::ScaleShift]}) - ofs;
    mag_full = scaled[rdconv_pkg::SignedW-1] ? -scaled : scaled;

    s2_d.status = s1_i.status;
    s2_d.neg    = scaled[rdconv_pkg::SignedW-1];
    s2_d.mag    = mag_full[rdconv_pkg::MagW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

// ===== hw/rtl/rdconv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading conversion divider
// Divides the magnitude by 1000 in two stages: a reciprocal multiply for the
// quotient, then a multiply-back and subtract for the remainder.
// ----------------------------------------------------------------------------
module rdconv_div (
  input  logic             clk_i,
  input  logic [1:0]       ld_i,
  input  rdconv_pkg::s2_t  s2_i,
  output rdconv_pkg::s4_t  s4_o
);

  localparam int unsigned RecipProdW = rdconv_pkg::MagW + rdconv_pkg::RecipW;

  rdconv_pkg::s3_t                 s3_d, s3_q;
  rdconv_pkg::s4_t                 s4_d, s4_q;
  logic [RecipProdW-1:0]           recip_prod;
  logic [rdconv_pkg::MagW-1:0]     back;

  // Quotient through the reciprocal.
  always_comb begin
    recip_prod  = RecipProdW'(s2_i.mag) * RecipProdW'(rdconv_pkg::RecipMul);
    s3_d.status = s2_i.status;
    s3_d.neg    = s2_i.neg;
    s3_d.mag    = s2_i.mag;
    s3_d.quot   = recip_prod[rdconv_pkg::RecipShift +: rdconv_pkg::QuotW];
  end

  // Remainder from the quotient.
  always_comb begin
    back        = rdconv_pkg::MagW'(s3_q.quot) * rdconv_pkg::MagW'(rdconv_pkg::Divisor);
    s4_d.status = s3_q.status;
    s4_d.neg    = s3_q.neg;
    s4_d.quot   = s3_q.quot;
    s4_d.rem    = rdconv_pkg::RemW'(s3_q.mag - back);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      s3_q <= s3_d;
    end
    if (ld_i[1]) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule
